FILE: rtl/core/fpws_pkg.sv
// Shared types, field widths and defaults of the flash page write splitter.
package fpws_pkg;

  localparam int ADDR_W = 24;
  localparam int COUNT_W = 14;
  localparam int CHUNK_BYTES_W = 9;
  localparam int OFFSET_W = 13;

  // The page size must be a power of two.
  localparam int PAGE_BYTES_DEF = 256;
  localparam int MAX_REQUEST_BYTES_DEF = 8192;

  // No request is split into more chunks than this.
  localparam int MAX_CHUNKS = 33;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic load;
    logic advance;
  } dp_cmd_t;

  typedef struct packed {
    logic req_empty;
    logic chunk_last;
  } dp_status_t;

endpackage

FILE: rtl/core/flash_page_write_splitter.sv
// Top level of the flash page write splitter: controller, datapath and checks.
// A request is taken while the block is idle and then gives one chunk beat per cycle while out_ready is high.
// The chunk count is set by the address cursor, which moves to the start of the next page on each beat but the last.
// A request of zero bytes is taken and gives no beat.
// Synchronous active-low reset returns the controller to idle; datapath registers are not reset.
module flash_page_write_splitter #(
  parameter int PAGE_BYTES = fpws_pkg::PAGE_BYTES_DEF,
  parameter int MAX_REQUEST_BYTES = fpws_pkg::MAX_REQUEST_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [fpws_pkg::ADDR_W-1:0]        in_start_address,
  input  logic [fpws_pkg::COUNT_W-1:0]       in_byte_count,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [fpws_pkg::ADDR_W-1:0]        out_chunk_address,
  output logic [fpws_pkg::CHUNK_BYTES_W-1:0] out_chunk_bytes,
  output logic [fpws_pkg::OFFSET_W-1:0]      out_buffer_offset,
  output logic                               out_last_chunk
);

  fpws_pkg::dp_cmd_t    cmd;
  fpws_pkg::dp_status_t status;

  fpws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  fpws_datapath #(
    .PAGE_BYTES        (PAGE_BYTES),
    .MAX_REQUEST_BYTES (MAX_REQUEST_BYTES)
  ) u_datapath (
    .clk           (clk),
    .cmd           (cmd),
    .status        (status),
    .start_address (in_start_address),
    .byte_count    (in_byte_count),
    .chunk_address (out_chunk_address),
    .chunk_bytes   (out_chunk_bytes),
    .buffer_offset (out_buffer_offset),
    .last_chunk    (out_last_chunk)
  );

  // A new request is never taken while chunk beats are pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while chunks pending");

  // The beat flagged as last ends the request.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_chunk) |=> (!out_valid && in_ready))
    else $error("chunk beat after last chunk");

  // An empty request produces no beat.
  a_empty_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_byte_count == '0) |=> !out_valid)
    else $error("beat produced for empty request");

  // A non-empty request always starts chunk beats.
  a_request_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_byte_count != '0) |=> out_valid)
    else $error("non-empty request produced no beat");

endmodule

FILE: rtl/core/fpws_datapath.sv
// Datapath holding the request cursor and forming one chunk per beat.
module fpws_datapath #(
  parameter int PAGE_BYTES = fpws_pkg::PAGE_BYTES_DEF,
  parameter int MAX_REQUEST_BYTES = fpws_pkg::MAX_REQUEST_BYTES_DEF
) (
  input  logic                               clk,
  input  fpws_pkg::dp_cmd_t                  cmd,
  output fpws_pkg::dp_status_t               status,
  input  logic [fpws_pkg::ADDR_W-1:0]        start_address,
  input  logic [fpws_pkg::COUNT_W-1:0]       byte_count,
  output logic [fpws_pkg::ADDR_W-1:0]        chunk_address,
  output logic [fpws_pkg::CHUNK_BYTES_W-1:0] chunk_bytes,
  output logic [fpws_pkg::OFFSET_W-1:0]      buffer_offset,
  output logic                               last_chunk
);

  localparam int AW = fpws_pkg::ADDR_W;
  localparam int CW = fpws_pkg::COUNT_W;
  localparam int MAX_CHUNKS = fpws_pkg::MAX_CHUNKS;
  localparam int IDX_W = $clog2(MAX_CHUNKS);

  logic [AW-1:0]    addr_r, addr_nxt;
  logic [CW-1:0]    remaining_r, remaining_nxt;
  logic [CW-1:0]    offset_r, offset_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  logic [CW-1:0] count_sat;
  logic [AW-1:0] page_low;
  logic [CW-1:0] room;
  logic [CW-1:0] len;
  logic [CW-1:0] rem_after;

  always_comb begin
    if (byte_count > CW'(MAX_REQUEST_BYTES)) begin
      count_sat = CW'(MAX_REQUEST_BYTES);
    end else begin
      count_sat = byte_count;
    end
    page_low  = addr_r & AW'(PAGE_BYTES - 1);
    room      = CW'(PAGE_BYTES) - CW'(page_low);
    len       = (remaining_r < room) ? remaining_r : room;
    rem_after = remaining_r - len;
  end

  always_comb begin
    addr_nxt      = addr_r;
    remaining_nxt = remaining_r;
    offset_nxt    = offset_r;
    idx_nxt       = idx_r;
    if (cmd.load) begin
      addr_nxt      = start_address;
      remaining_nxt = count_sat;
      offset_nxt    = '0;
      idx_nxt       = '0;
    end else if (cmd.advance) begin
      addr_nxt      = addr_r + AW'(len);
      remaining_nxt = rem_after;
      offset_nxt    = offset_r + len;
      idx_nxt       = idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    addr_r      <= addr_nxt;
    remaining_r <= remaining_nxt;
    offset_r    <= offset_nxt;
    idx_r       <= idx_nxt;
  end

  assign status.req_empty  = (count_sat == '0);
  assign status.chunk_last = (rem_after == '0) || (idx_r == IDX_W'(MAX_CHUNKS - 1));

  assign chunk_address = addr_r;
  assign chunk_bytes   = len[fpws_pkg::CHUNK_BYTES_W-1:0];
  assign buffer_offset = offset_r[fpws_pkg::OFFSET_W-1:0];
  assign last_chunk    = status.chunk_last;

endmodule

FILE: rtl/core/fpws_ctrl.sv
// Controller state machine sequencing request loads and chunk beats.
module fpws_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  fpws_pkg::dp_status_t status,
  output fpws_pkg::dp_cmd_t    cmd
);

  fpws_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fpws_pkg::ST_IDLE: begin
        if (in_valid && !status.req_empty) begin
          state_nxt = fpws_pkg::ST_RUN;
        end
      end
      fpws_pkg::ST_RUN: begin
        if (out_ready && status.chunk_last) begin
          state_nxt = fpws_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fpws_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd.load    = 1'b0;
    cmd.advance = 1'b0;
    case (state_r)
      fpws_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      fpws_pkg::ST_RUN: begin
        out_valid   = 1'b1;
        cmd.advance = out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fpws_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
